// ===== rtl/core/gpc_pkg.sv =====
// ----------------------------------------------------------------------------
// gpc_pkg
// Shared constants, types and modular arithmetic for the grid path counter.
// ----------------------------------------------------------------------------
package gpc_pkg;

   localparam int unsigned MAX_COLS = 1024;
   localparam int unsigned MAX_ROWS = 1024;

   localparam int unsigned COL_W   = $clog2(MAX_COLS);
   localparam int unsigned ROW_W   = $clog2(MAX_ROWS);
   localparam int unsigned DIM_W   = 11;
   localparam int unsigned LABEL_W = 32;
   localparam int unsigned CNT_W   = 30;
   localparam int unsigned CSR_W   = 32;
   localparam int unsigned CSR_IDX_W = 2;

   localparam logic [CNT_W-1:0] PRIME_MOD = CNT_W'(998244353);

   localparam logic [DIM_W-1:0] MAX_COLS_DIM = DIM_W'(MAX_COLS);
   localparam logic [DIM_W-1:0] MAX_ROWS_DIM = DIM_W'(MAX_ROWS);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GRID_ROWS    = 2'd0,
      CSR_GRID_COLS    = 2'd1,
      CSR_MARKED_VALUE = 2'd2
   } csr_index_type;

   // path counts of one cell: all paths and paths that avoid marked cells
   typedef struct packed {
      logic [CNT_W-1:0] total;
      logic [CNT_W-1:0] avoid;
   } counts_type;

   function automatic logic [CNT_W-1:0] mod_add(input logic [CNT_W-1:0] a,
                                                input logic [CNT_W-1:0] b);
      logic [CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, PRIME_MOD}) begin
         s = s - {1'b0, PRIME_MOD};
      end
      return s[CNT_W-1:0];
   endfunction

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
                                                  input logic [DIM_W-1:0] maxv);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > maxv) begin
         r = maxv;
      end
      return r;
   endfunction

endpackage

// ===== rtl/core/gpc_rsp_queue.sv =====
// ----------------------------------------------------------------------------
// gpc_rsp_queue
// Two-entry result queue; forms the through-marked count on the way out.
// ----------------------------------------------------------------------------
module gpc_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  gpc_pkg::counts_type   push_item,
   output logic [1:0]            count,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [63:0]           rsp_tdata   // [29:0] paths_through_marked,
                                             // [59:30] paths_avoiding_marked
);

   gpc_pkg::counts_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff,  count_in;

   gpc_pkg::counts_type     head;
   logic [gpc_pkg::CNT_W-1:0] through;

   assign head       = slot_ff[rd_ptr_ff];
   assign rsp_tvalid = (count_ff != 2'd0);
   assign pop        = rsp_tvalid && rsp_tready;
   assign count      = count_ff;

   // total - avoid, kept in range by adding the prime first
   assign through = gpc_pkg::mod_add(head.total, gpc_pkg::PRIME_MOD - head.avoid);
   assign rsp_tdata = {4'd0, head.avoid, through};

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue overfilled");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |-> count_ff != 2'd2)
      else $error("result pushed into full queue");

   assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count lost a push");

endmodule

// ===== rtl/core/grid_path_count_through_marked.sv =====
// ----------------------------------------------------------------------------
// grid_path_count_through_marked
// Streams grid cell labels and counts monotone lattice paths modulo a prime.
// ----------------------------------------------------------------------------
// Cell labels enter one item per clock in row-major order. Each item passes a
// first stage that reads the row buffer (one 60-bit synchronous RAM holding
// both counts of the cell above), then a second that adds above and left,
// writes the buffer back and, at the bottom-right cell, queues one result.
// With a one-column grid the cell above is still being written when the next
// read issues; a forwarding register covers that case. Sustained rate is one
// item per cycle; the input stalls only while the two-entry result queue plus
// a result still in flight would overflow, i.e. when results back up at the
// output. A write to grid_rows or grid_cols restarts the grid at the top-left.
// ----------------------------------------------------------------------------
module grid_path_count_through_marked (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,    // [31:0] cell_label
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata,    // [29:0] paths_through_marked,
                                     // [59:30] paths_avoiding_marked
   input  logic        csr_wen,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   localparam int unsigned COL_W = gpc_pkg::COL_W;
   localparam int unsigned ROW_W = gpc_pkg::ROW_W;
   localparam int unsigned DIM_W = gpc_pkg::DIM_W;
   localparam int unsigned CNT_W = gpc_pkg::CNT_W;

   // configuration
   logic [DIM_W-1:0]             grid_rows_ff, grid_rows_in;
   logic [DIM_W-1:0]             grid_cols_ff, grid_cols_in;
   logic [gpc_pkg::LABEL_W-1:0]  marked_value_ff, marked_value_in;
   logic                         restart;

   logic [DIM_W-1:0] rows_eff, cols_eff;

   // position of the next item
   logic [ROW_W-1:0] row_ff, row_in;
   logic [COL_W-1:0] col_ff, col_in;

   // second stage
   logic             s1_valid_ff, s1_valid_in;
   logic [COL_W-1:0] s1_col_ff;
   logic             s1_row0_ff, s1_col0_ff, s1_marked_ff, s1_last_ff;
   logic             fwd_hit_ff;
   gpc_pkg::counts_type fwd_data_ff;
   gpc_pkg::counts_type left_ff;

   // row buffer
   gpc_pkg::counts_type row_mem [gpc_pkg::MAX_COLS];
   gpc_pkg::counts_type mem_q_ff;

   logic accept, last_col, last_row, last_cell;
   gpc_pkg::counts_type up, left, cur;

   logic [1:0] q_count;
   logic       q_pop;

   // ---- configuration ----
   always_comb begin
      grid_rows_in    = grid_rows_ff;
      grid_cols_in    = grid_cols_ff;
      marked_value_in = marked_value_ff;
      restart         = 1'b0;
      if (csr_wen) begin
         case (csr_index)
            gpc_pkg::CSR_GRID_ROWS: begin
               grid_rows_in = csr_wdata[DIM_W-1:0];
               restart      = 1'b1;
            end
            gpc_pkg::CSR_GRID_COLS: begin
               grid_cols_in = csr_wdata[DIM_W-1:0];
               restart      = 1'b1;
            end
            gpc_pkg::CSR_MARKED_VALUE: begin
               marked_value_in = csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_rows_ff    <= DIM_W'(1);
         grid_cols_ff    <= DIM_W'(1);
         marked_value_ff <= '0;
      end else begin
         grid_rows_ff    <= grid_rows_in;
         grid_cols_ff    <= grid_cols_in;
         marked_value_ff <= marked_value_in;
      end
   end

   assign rows_eff = gpc_pkg::clamp_dim(grid_rows_ff, gpc_pkg::MAX_ROWS_DIM);
   assign cols_eff = gpc_pkg::clamp_dim(grid_cols_ff, gpc_pkg::MAX_COLS_DIM);

   // ---- first stage: position, row buffer read ----
   // room is needed for this item's result, which is pushed in the next cycle
   assign req_tready = ({1'b0, q_count} + {2'b0, s1_valid_ff && s1_last_ff}
                        - {2'b0, q_pop}) <= 3'd1;
   assign accept     = req_tvalid && req_tready;

   assign last_col  = ({1'b0, col_ff} + DIM_W'(1)) >= cols_eff;
   assign last_row  = ({1'b0, row_ff} + DIM_W'(1)) >= rows_eff;
   assign last_cell = last_col && last_row;

   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (restart) begin
         row_in = '0;
         col_in = '0;
      end else if (accept) begin
         if (last_cell) begin
            row_in = '0;
            col_in = '0;
         end else if (last_col) begin
            row_in = row_ff + ROW_W'(1);
            col_in = '0;
         end else begin
            col_in = col_ff + COL_W'(1);
         end
      end
   end

   assign s1_valid_in = accept;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff      <= '0;
         col_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         row_ff      <= row_in;
         col_ff      <= col_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_col_ff    <= col_ff;
         s1_row0_ff   <= (row_ff == '0);
         s1_col0_ff   <= (col_ff == '0);
         s1_marked_ff <= (req_tdata == marked_value_ff);
         s1_last_ff   <= last_cell;
         // entry being written back this cycle is read stale by the RAM
         fwd_hit_ff   <= s1_valid_ff && (s1_col_ff == col_ff);
         fwd_data_ff  <= cur;
      end
   end

   always_ff @(posedge clock) begin
      mem_q_ff <= row_mem[col_ff];
      if (s1_valid_ff) begin
         row_mem[s1_col_ff] <= cur;
      end
   end

   // ---- second stage: combine above and left ----
   always_comb begin
      up   = '0;
      left = '0;
      if (!s1_row0_ff) begin
         up = fwd_hit_ff ? fwd_data_ff : mem_q_ff;
      end
      if (!s1_col0_ff) begin
         left = left_ff;
      end
      if (s1_row0_ff && s1_col0_ff) begin
         cur.total = CNT_W'(1);
         cur.avoid = s1_marked_ff ? '0 : CNT_W'(1);
      end else begin
         cur.total = gpc_pkg::mod_add(up.total, left.total);
         cur.avoid = s1_marked_ff ? '0 : gpc_pkg::mod_add(up.avoid, left.avoid);
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff) begin
         left_ff <= cur;
      end
   end

   gpc_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (s1_valid_ff && s1_last_ff),
      .push_item  (cur),
      .count      (q_count),
      .pop        (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < cols_eff) && ({1'b0, row_ff} < rows_eff))
      else $error("grid position outside configured size");

   assert property (@(posedge clock) disable iff (reset)
      accept && last_cell |=> row_ff == '0 && col_ff == '0)
      else $error("grid did not restart after final cell");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |-> q_count != 2'd2 || q_pop)
      else $error("final cell arrived with no room for its result");

   assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_marked_ff |-> cur.avoid == '0)
      else $error("marked cell carries avoiding paths");

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the grid path counter. Cell labels are streamed in
// row-major order under random back-pressure on both sides. An in-bench
// model of the row-buffer DP predicts both path counts at every bottom-right
// cell. Each result is checked against that prediction in order. Grid sizes
// and the marked label are changed between phases while the block is idle.
// ----------------------------------------------------------------------------
module tb;

   localparam logic [1:0] CSR_SPARE  = 2'd3;   // outside the register map
   localparam int         IDLE_PCT   = 28;
   localparam int         HOLD_LEN   = 300;
   localparam int         STUCK_MAX  = 2000;
   localparam int         DRAIN_WAIT = 8;

   typedef struct packed {
      logic [gpc_pkg::CNT_W-1:0] through;
      logic [gpc_pkg::CNT_W-1:0] avoid;
   } path_counts_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [63:0] rsp_tdata;
   logic        csr_wen    = 1'b0;
   logic [1:0]  csr_index  = '0;
   logic [31:0] csr_wdata  = '0;

   grid_path_count_through_marked uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   wire in_fire  = req_tvalid & req_tready;
   wire out_fire = rsp_tvalid & rsp_tready;

   logic [31:0]     cells_pending [$];
   path_counts_type counts_due [$];
   path_counts_type next_counts;
   path_counts_type want;
   int              mismatches   = 0;
   int              results_seen = 0;
   int              stuck_cycles = 0;
   int              hold_left    = 0;
   bit              hold_done    = 1'b0;
   bit              hold_armed   = 1'b0;
   bit              steady       = 1'b0;

   // model state: register copies, row buffers, left counts, position
   logic [gpc_pkg::DIM_W-1:0] rows_reg   = 11'd1;
   logic [gpc_pkg::DIM_W-1:0] cols_reg   = 11'd1;
   logic [31:0]               marked_reg = '0;
   logic [gpc_pkg::CNT_W-1:0] avoid_line [gpc_pkg::MAX_COLS];
   logic [gpc_pkg::CNT_W-1:0] total_line [gpc_pkg::MAX_COLS];
   logic [gpc_pkg::CNT_W-1:0] avoid_prev = '0;
   logic [gpc_pkg::CNT_W-1:0] total_prev = '0;
   int unsigned               row_pos    = 0;
   int unsigned               col_pos    = 0;

   function automatic logic [gpc_pkg::CNT_W-1:0] add_mod(
         input logic [gpc_pkg::CNT_W-1:0] a,
         input logic [gpc_pkg::CNT_W-1:0] b);
      logic [gpc_pkg::CNT_W:0] s;
      s = {1'b0, a} + {1'b0, b};
      if (s >= {1'b0, gpc_pkg::PRIME_MOD}) begin
         s = s - {1'b0, gpc_pkg::PRIME_MOD};
      end
      return s[gpc_pkg::CNT_W-1:0];
   endfunction

   function automatic int unsigned dim_used(input logic [gpc_pkg::DIM_W-1:0] v,
                                            input int unsigned top);
      if (v == '0) begin
         return 1;
      end
      if (v > top) begin
         return top;
      end
      return 32'(v);
   endfunction

   function automatic void restart_grid();
      row_pos    = 0;
      col_pos    = 0;
      avoid_prev = '0;
      total_prev = '0;
   endfunction

   // one cell through the DP; returns 1 when the cell closes the grid
   function automatic bit count_cell(input logic [31:0] label,
                                     output path_counts_type res);
      int unsigned               rows;
      int unsigned               cols;
      logic [gpc_pkg::CNT_W-1:0] up_a;
      logic [gpc_pkg::CNT_W-1:0] up_t;
      logic [gpc_pkg::CNT_W-1:0] lf_a;
      logic [gpc_pkg::CNT_W-1:0] lf_t;
      logic [gpc_pkg::CNT_W-1:0] a;
      logic [gpc_pkg::CNT_W-1:0] t;
      bit                        hit;
      rows = dim_used(rows_reg, gpc_pkg::MAX_ROWS);
      cols = dim_used(cols_reg, gpc_pkg::MAX_COLS);
      hit  = (label == marked_reg);
      up_a = '0;
      up_t = '0;
      lf_a = '0;
      lf_t = '0;
      res  = '0;
      if (row_pos > 0) begin
         up_a = avoid_line[col_pos[gpc_pkg::COL_W-1:0]];
         up_t = total_line[col_pos[gpc_pkg::COL_W-1:0]];
      end
      if (col_pos > 0) begin
         lf_a = avoid_prev;
         lf_t = total_prev;
      end
      if (row_pos == 0 && col_pos == 0) begin
         t = gpc_pkg::CNT_W'(1);
         a = hit ? '0 : gpc_pkg::CNT_W'(1);
      end else begin
         t = add_mod(up_t, lf_t);
         a = hit ? '0 : add_mod(up_a, lf_a);
      end
      avoid_line[col_pos[gpc_pkg::COL_W-1:0]] = a;
      total_line[col_pos[gpc_pkg::COL_W-1:0]] = t;
      avoid_prev = a;
      total_prev = t;
      if (row_pos + 1 >= rows && col_pos + 1 >= cols) begin
         res.through = add_mod(t, gpc_pkg::PRIME_MOD - a);
         res.avoid   = a;
         restart_grid();
         return 1'b1;
      end
      if (col_pos + 1 >= cols) begin
         col_pos = 0;
         row_pos = row_pos + 1;
      end else begin
         col_pos = col_pos + 1;
      end
      return 1'b0;
   endfunction

   // driver: offers the next pending label, predicts on acceptance
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_tvalid) begin
            if (count_cell(req_tdata, next_counts)) begin
               counts_due = {counts_due, next_counts};
            end
         end
         if (cells_pending.size() != 0 && (steady || $urandom_range(99) >= IDLE_PCT)) begin
            req_tvalid <= 1'b1;
            req_tdata  <= cells_pending.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // monitor: checks results in order and drives rsp_tready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (out_fire) begin
            results_seen <= results_seen + 1;
            if (counts_due.size() == 0) begin
               if (mismatches < 10) begin
                  $display("ERROR: unexpected result through=%0d avoid=%0d",
                           rsp_tdata[29:0], rsp_tdata[59:30]);
               end
               mismatches <= mismatches + 1;
            end else begin
               want = counts_due.pop_front();
               if (rsp_tdata[29:0] !== want.through || rsp_tdata[59:30] !== want.avoid ||
                   rsp_tdata[63:60] !== 4'd0) begin
                  if (mismatches < 10) begin
                     $display({"ERROR: result %0d: through exp %0d got %0d, ",
                               "avoid exp %0d got %0d, pad %h"},
                              results_seen, want.through, rsp_tdata[29:0],
                              want.avoid, rsp_tdata[59:30], rsp_tdata[63:60]);
                  end
                  mismatches <= mismatches + 1;
               end
            end
         end
         // one long hold-off so the result queue backs up into the input
         if (hold_left != 0) begin
            hold_left  <= hold_left - 1;
            rsp_tready <= 1'b0;
         end else if (hold_armed && !hold_done) begin
            hold_done  <= 1'b1;
            hold_left  <= HOLD_LEN;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (in_fire || out_fire) begin
            stuck_cycles <= 0;
         end else if (stuck_cycles >= STUCK_MAX) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
         end else begin
            stuck_cycles <= stuck_cycles + 1;
         end
      end
   end

   task automatic write_csr(input logic [1:0] idx, input logic [31:0] data);
      @(posedge clock);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wen   <= 1'b0;
      case (idx)
         gpc_pkg::CSR_GRID_ROWS: begin
            rows_reg = data[gpc_pkg::DIM_W-1:0];
            restart_grid();
         end
         gpc_pkg::CSR_GRID_COLS: begin
            cols_reg = data[gpc_pkg::DIM_W-1:0];
            restart_grid();
         end
         gpc_pkg::CSR_MARKED_VALUE: begin
            marked_reg = data;
         end
         default: begin
         end
      endcase
   endtask

   // dims only use the low bits; junk above them must be ignored
   task automatic write_dim(input logic [1:0] idx,
                            input logic [gpc_pkg::DIM_W-1:0] dim);
      write_csr(idx, ($urandom() & 32'hFFFF_F800) | 32'(dim));
   endtask

   task automatic queue_cells(input int n, input int pct);
      logic [31:0] label;
      for (int i = 0; i < n; i++) begin
         label = ($urandom_range(99) < pct) ? marked_reg : $urandom();
         cells_pending = {cells_pending, label};
      end
   endtask

   task automatic queue_one(input logic [31:0] label);
      cells_pending = {cells_pending, label};
   endtask

   // block is idle once everything is offered, answered and the pipe drained
   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (cells_pending.size() != 0 || req_tvalid || counts_due.size() != 0);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   function automatic logic [gpc_pkg::DIM_W-1:0] pick_small_dim();
      return ($urandom_range(9) == 0) ? 11'd0 : 11'($urandom_range(1, 6));
   endfunction

   initial begin
      int          n;
      int          cells;
      int          small_cells;
      logic [31:0] mark;
      small_cells = 0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // 1x1 grid at reset values: marked start cell, then unmarked extremes
      queue_one(32'h0000_0000);
      queue_one(32'hFFFF_FFFF);
      queue_one(32'h0000_0001);
      wait_idle();

      // zero sizes fall back to one; spare index is ignored
      write_csr(CSR_SPARE, 32'h0000_0007);
      write_csr(gpc_pkg::CSR_GRID_ROWS, 32'hFFFF_F800);
      write_csr(gpc_pkg::CSR_GRID_COLS, 32'h0000_0000);
      write_csr(gpc_pkg::CSR_MARKED_VALUE, 32'hFFFF_FFFF);
      queue_one(32'hFFFF_FFFF);
      queue_one(32'h0000_0000);
      queue_one(32'h7FFF_FFFF);
      wait_idle();

      // 3x3 with the centre blocked, then 2x2 with the final cell blocked
      write_csr(gpc_pkg::CSR_GRID_ROWS, 32'd3);
      write_csr(gpc_pkg::CSR_GRID_COLS, 32'd3);
      write_csr(gpc_pkg::CSR_MARKED_VALUE, 32'd5);
      for (int i = 1; i <= 9; i++) begin
         queue_one(32'(i));
      end
      wait_idle();
      write_csr(gpc_pkg::CSR_GRID_ROWS, 32'd2);
      write_csr(gpc_pkg::CSR_GRID_COLS, 32'd2);
      queue_one(32'd9);
      queue_one(32'd9);
      queue_one(32'd9);
      queue_one(32'd5);
      wait_idle();

      // marked label changed half way through a grid
      queue_one(32'd5);
      queue_one(32'd7);
      wait_idle();
      write_csr(gpc_pkg::CSR_MARKED_VALUE, 32'd7);
      queue_one(32'd7);
      queue_one(32'd1);
      wait_idle();

      // tiny grids with the receiver held off
      write_dim(gpc_pkg::CSR_GRID_ROWS, 11'd1);
      write_dim(gpc_pkg::CSR_GRID_COLS, 11'($urandom_range(1, 2)));
      write_csr(gpc_pkg::CSR_MARKED_VALUE, $urandom());
      queue_cells(30, 30);
      hold_armed = 1'b1;
      wait_idle();

      // random small grids, some left unfinished
      while (small_cells < 40) begin
         if ($urandom_range(7) == 0) begin
            write_csr(CSR_SPARE, $urandom());
         end
         if ($urandom_range(4) != 0) begin
            write_dim(gpc_pkg::CSR_GRID_ROWS, pick_small_dim());
            write_dim(gpc_pkg::CSR_GRID_COLS, pick_small_dim());
         end
         case ($urandom_range(3))
            0:       mark = 32'h0000_0000;
            1:       mark = 32'hFFFF_FFFF;
            default: mark = $urandom();
         endcase
         write_csr(gpc_pkg::CSR_MARKED_VALUE, mark);
         cells = dim_used(rows_reg, gpc_pkg::MAX_ROWS) * dim_used(cols_reg, gpc_pkg::MAX_COLS);
         n = cells * $urandom_range(1, 4);
         if (cells > 1 && $urandom_range(3) == 0) begin
            n = n + $urandom_range(1, cells - 1);
         end
         queue_cells(n, $urandom_range(0, 40));
         small_cells = small_cells + n;
         wait_idle();
      end

      // 17x18 is a grid whose count passes the prime
      write_dim(gpc_pkg::CSR_GRID_ROWS, 11'd17);
      write_dim(gpc_pkg::CSR_GRID_COLS, 11'd18);
      write_csr(gpc_pkg::CSR_MARKED_VALUE, $urandom());
      queue_cells(17 * 18, 2);
      wait_idle();

      // oversized row count, abandoned part way by the next size write
      write_dim(gpc_pkg::CSR_GRID_ROWS, 11'd2047);
      write_dim(gpc_pkg::CSR_GRID_COLS, 11'd2);
      queue_cells(20, 10);
      wait_idle();

      // one full-width row, both sides without gaps
      steady = 1'b1;
      write_dim(gpc_pkg::CSR_GRID_ROWS, 11'd0);
      write_dim(gpc_pkg::CSR_GRID_COLS, 11'd2047);
      write_csr(gpc_pkg::CSR_MARKED_VALUE, $urandom());
      queue_cells(gpc_pkg::MAX_COLS, 1);
      wait_idle();
      steady = 1'b0;

      if (mismatches == 0 && counts_due.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
